@@ src/mbps_pkg.sv @@
// shared constants, types and helpers for the masked byte pattern scanner
// no dependencies; imported by every module of the scanner

package mbps_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int OFFSET_BITS = 32;

   localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
   localparam int LEN_CAP   = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
   localparam int POS_BITS  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   localparam int LEN_BITS   = 5;
   localparam int BYTE_BITS  = 8;
   localparam int CSR_BITS   = 64;
   localparam int INDEX_BITS = 3;
   localparam int RSP_OFFSET_BITS = 32;

   localparam logic [INDEX_BITS-1:0] REG_VALUES_LOW  = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_VALUES_HIGH = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_MASKS_LOW   = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_MASKS_HIGH  = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_LENGTH      = 3'd4;

   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

   typedef logic [PATTERN_MAX-1:0][BYTE_BITS-1:0] pat_bytes_type;

   typedef struct packed {
      logic                       found;
      logic [RSP_OFFSET_BITS-1:0] match_offset;
   } rsp_word_type;

   // masked compare of one byte against one pattern position
   function automatic logic byte_hit(input logic [BYTE_BITS-1:0] d,
                                     input logic [BYTE_BITS-1:0] m,
                                     input logic [BYTE_BITS-1:0] v);
      return (d & m) == v;
   endfunction

   // length as the compare logic uses it: zero means one, capped at LEN_CAP
   function automatic logic [LEN_BITS-1:0] clamp_length(input logic [LEN_BITS-1:0] raw);
      logic [LEN_BITS-1:0] res;
      res = raw;
      if (raw == '0) begin
         res = LEN_BITS'(1);
      end else if (raw > LEN_BITS'(LEN_CAP)) begin
         res = LEN_BITS'(LEN_CAP);
      end
      return res;
   endfunction

endpackage

@@ src/mbps_cell.sv @@
// one window cell: holds one earlier byte of the region, passes it on each word,
// and compares it against the pattern position that lines up with it; uses mbps_pkg

module mbps_cell
   import mbps_pkg::*;
(
   input  logic                 clock,
   input  logic                 shift_en,
   input  logic [BYTE_BITS-1:0] byte_in,
   output logic [BYTE_BITS-1:0] byte_out,
   input  logic                 cell_active,
   input  logic [POS_BITS-1:0]  cell_pos,
   input  pat_bytes_type        pat_values,
   input  pat_bytes_type        pat_masks,
   output logic                 cell_ok
);

   logic [BYTE_BITS-1:0] byte_ff;
   logic [BYTE_BITS-1:0] byte_in_sel;

   assign byte_in_sel = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_sel;
   end

   assign byte_out = byte_ff;

   // cells past the pattern's reach always agree
   assign cell_ok = !cell_active ||
                    byte_hit(byte_ff, pat_masks[cell_pos], pat_values[cell_pos]);

endmodule

@@ src/mbps_rsp_buf.sv @@
// two-entry result buffer: output register plus skid entry
// uses mbps_pkg for the result word type

module mbps_rsp_buf
   import mbps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         has_room,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic         head_valid_ff, head_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type head_ff, head_in;
   rsp_word_type skid_ff, skid_in;
   logic         pop;

   assign pop      = head_valid_ff && rsp_ready;
   assign has_room = !skid_valid_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = push_word;
            skid_valid_in = push;
         end else begin
            head_in       = push_word;
            head_valid_in = push;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = push_word;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = head_valid_ff;
   assign rsp_word  = head_ff;

endmodule

@@ src/masked_byte_pattern_scanner_unit.sv @@
// Masked byte pattern scanner. Takes one byte per clock while the output buffer has
// room, and finds the first place in a region where the masked pattern (up to 16
// bytes, byte & mask == value per position) matches. The earlier bytes sit in a
// chain of 15 cells that shift once per accepted word; every cell compares its byte
// against the pattern position it currently lines up with, so the whole pattern is
// checked in the cycle the byte arrives. The result (found with the match start
// offset, or not found on the region's last byte) is registered into a two-entry
// output buffer, head register then skid entry; the input stalls only when both
// entries are held. Offsets count from the region start and saturate. Registers
// 0..3 hold pattern values and masks, low positions in the low bytes; register 4 is
// the length. Depends on mbps_pkg, mbps_cell and mbps_rsp_buf.

module masked_byte_pattern_scanner_unit
   import mbps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_BITS-1:0]       req_data_byte,
   input  logic                       req_region_first,
   input  logic                       req_region_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic [RSP_OFFSET_BITS-1:0] rsp_match_offset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [INDEX_BITS-1:0]      csr_index,
   input  logic [CSR_BITS-1:0]        csr_wdata
);

   pat_bytes_type        pat_values_ff;
   pat_bytes_type        pat_masks_ff;
   logic [LEN_BITS-1:0]  pat_len_ff;

   logic [OFFSET_BITS-1:0] bytes_seen_ff, bytes_seen_in;
   logic                   match_done_ff, match_done_in;

   logic                   accept;
   logic                   csr_write;
   logic                   buf_room;
   logic [OFFSET_BITS-1:0] seen_base;
   logic [OFFSET_BITS-1:0] have;
   logic [OFFSET_BITS-1:0] len_wide;
   logic [OFFSET_BITS-1:0] match_off;
   logic                   done_base;
   logic                   enough;
   logic                   all_ok;
   logic                   hit;
   logic                   push;
   rsp_word_type           push_word;
   rsp_word_type           out_word;

   logic [WIN_DEPTH-1:0][BYTE_BITS-1:0] cell_byte;
   logic [WIN_DEPTH-1:0]                cell_ok;
   logic [POS_BITS-1:0]                 cur_pos;
   logic                                cur_ok;

   // configuration
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_values_ff <= '0;
         pat_masks_ff  <= '0;
         pat_len_ff    <= LEN_BITS'(1);
      end else if (csr_write) begin
         for (int p = 0; p < PATTERN_MAX; p++) begin
            if ((p < 8 && csr_index == REG_VALUES_LOW) ||
                (p >= 8 && p < 16 && csr_index == REG_VALUES_HIGH)) begin
               pat_values_ff[p] <= csr_wdata[8*(p%8) +: BYTE_BITS];
            end
            if ((p < 8 && csr_index == REG_MASKS_LOW) ||
                (p >= 8 && p < 16 && csr_index == REG_MASKS_HIGH)) begin
               pat_masks_ff[p] <= csr_wdata[8*(p%8) +: BYTE_BITS];
            end
         end
         if (csr_index == REG_LENGTH) begin
            pat_len_ff <= clamp_length(csr_wdata[LEN_BITS-1:0]);
         end
      end
   end

   // cell chain, cell 0 holds the byte just before the current one
   for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
      logic                 active;
      logic [POS_BITS-1:0]  pos;
      logic [BYTE_BITS-1:0] nb_byte;

      assign active  = pat_len_ff >= LEN_BITS'(k + 2);
      assign pos     = POS_BITS'(pat_len_ff - LEN_BITS'(k + 2));
      assign nb_byte = (k == 0) ? req_data_byte : cell_byte[(k == 0) ? 0 : k - 1];

      mbps_cell u_cell (
         .clock       (clock),
         .shift_en    (accept),
         .byte_in     (nb_byte),
         .byte_out    (cell_byte[k]),
         .cell_active (active),
         .cell_pos    (pos),
         .pat_values  (pat_values_ff),
         .pat_masks   (pat_masks_ff),
         .cell_ok     (cell_ok[k])
      );
   end

   // the current byte lines up with the last pattern position
   assign cur_pos = POS_BITS'(pat_len_ff - LEN_BITS'(1));
   assign cur_ok  = byte_hit(req_data_byte, pat_masks_ff[cur_pos], pat_values_ff[cur_pos]);
   assign all_ok  = cur_ok && (&cell_ok);

   // region bookkeeping
   assign accept    = req_valid && req_ready;
   assign seen_base = req_region_first ? '0 : bytes_seen_ff;
   assign done_base = req_region_first ? 1'b0 : match_done_ff;
   assign have      = (seen_base == COUNT_MAX) ? COUNT_MAX : seen_base + OFFSET_BITS'(1);
   assign len_wide  = OFFSET_BITS'(pat_len_ff);
   assign enough    = have >= len_wide;
   assign match_off = have - len_wide;

   assign hit  = !done_base && enough && all_ok;
   assign push = accept && (hit || (req_region_last && !done_base));

   assign push_word.found        = hit;
   assign push_word.match_offset = hit ? RSP_OFFSET_BITS'(match_off) : '0;

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      match_done_in = match_done_ff;
      if (accept) begin
         if (req_region_last) begin
            bytes_seen_in = '0;
            match_done_in = 1'b0;
         end else begin
            bytes_seen_in = have;
            match_done_in = done_base || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         match_done_ff <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         match_done_ff <= match_done_in;
      end
   end

   assign req_ready = buf_room;

   mbps_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .has_room  (buf_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (out_word)
   );

   assign rsp_found        = out_word.found;
   assign rsp_match_offset = out_word.match_offset;

endmodule

@@ dv/mbps_scan_checker.sv @@
`timescale 1ns / 100ps
// scoreboard for the masked byte pattern scanner: follows register writes and input words,
// predicts each region's result, and compares the result channel word by word
// depends on mbps_pkg

module mbps_scan_checker
   import mbps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [BYTE_BITS-1:0]       req_data_byte,
   input  logic                       req_region_first,
   input  logic                       req_region_last,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_found,
   input  logic [RSP_OFFSET_BITS-1:0] rsp_match_offset,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [INDEX_BITS-1:0]      csr_index,
   input  logic [CSR_BITS-1:0]        csr_wdata,
   output int                         fail_count,
   output int                         words_outstanding,
   output int                         results_checked
);

   logic [CSR_BITS-1:0]    values_low;
   logic [CSR_BITS-1:0]    values_high;
   logic [CSR_BITS-1:0]    masks_low;
   logic [CSR_BITS-1:0]    masks_high;
   logic [LEN_BITS-1:0]    length_raw;
   logic [BYTE_BITS-1:0]   history [WIN_DEPTH];
   logic [OFFSET_BITS-1:0] bytes_seen;
   logic                   match_done;
   rsp_word_type           expected_results [$];

   function automatic logic [BYTE_BITS-1:0] pattern_lane(input logic [CSR_BITS-1:0] lo,
                                                         input logic [CSR_BITS-1:0] hi,
                                                         input int pos);
      logic [CSR_BITS-1:0] w;
      w = (pos < 8) ? lo : hi;
      return w[8*(pos%8) +: BYTE_BITS];
   endfunction

   task automatic clear_region();
      int i;
      for (i = 0; i < WIN_DEPTH; i++) begin
         history[i] = '0;
      end
      bytes_seen = '0;
      match_done = 1'b0;
   endtask

   task automatic scan_byte(input logic [BYTE_BITS-1:0] b, input logic is_first,
                            input logic is_last);
      int                     len;
      int                     i;
      int                     back;
      logic [OFFSET_BITS-1:0] have;
      logic [BYTE_BITS-1:0]   d;
      logic                   hit;
      rsp_word_type           w;
      len = (length_raw == '0) ? 1 :
            ((length_raw > LEN_BITS'(LEN_CAP)) ? LEN_CAP : int'(length_raw));
      if (is_first) begin
         clear_region();
      end
      have = (bytes_seen < COUNT_MAX) ? bytes_seen + 1'b1 : COUNT_MAX;
      if (!match_done && have >= OFFSET_BITS'(len)) begin
         hit = 1'b1;
         for (i = 0; i < len; i++) begin
            back = len - 1 - i;
            d = (back == 0) ? b : history[back-1];
            if ((d & pattern_lane(masks_low, masks_high, i)) !=
                pattern_lane(values_low, values_high, i)) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            w.found = 1'b1;
            w.match_offset = RSP_OFFSET_BITS'(have - OFFSET_BITS'(len));
            expected_results.push_back(w);
            match_done = 1'b1;
         end
      end
      if (is_last && !match_done) begin
         w.found = 1'b0;
         w.match_offset = '0;
         expected_results.push_back(w);
      end
      if (is_last) begin
         clear_region();
      end else begin
         for (i = WIN_DEPTH - 1; i > 0; i--) begin
            history[i] = history[i-1];
         end
         history[0] = b;
         bytes_seen = have;
      end
   endtask

   // predict before comparing, so a word accepted this edge queues behind older ones
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         values_low = '0;
         values_high = '0;
         masks_low = '0;
         masks_high = '0;
         length_raw = LEN_BITS'(1);
         clear_region();
         expected_results.delete();
         fail_count = 0;
         results_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_VALUES_LOW: begin
                  values_low = csr_wdata;
               end
               REG_VALUES_HIGH: begin
                  values_high = csr_wdata;
               end
               REG_MASKS_LOW: begin
                  masks_low = csr_wdata;
               end
               REG_MASKS_HIGH: begin
                  masks_high = csr_wdata;
               end
               REG_LENGTH: begin
                  length_raw = csr_wdata[LEN_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            scan_byte(req_data_byte, req_region_first, req_region_last);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected, actual found=%0b offset=%0d",
                        $time, rsp_found, rsp_match_offset);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_found !== want.found) begin
                  fail_count++;
                  $display("%0t: found mismatch, expected %0b actual %0b",
                           $time, want.found, rsp_found);
               end
               if (rsp_match_offset !== want.match_offset) begin
                  fail_count++;
                  $display("%0t: match_offset mismatch, expected %0d actual %0d",
                           $time, want.match_offset, rsp_match_offset);
               end
            end
         end
      end
      words_outstanding = expected_results.size();
   end

endmodule

@@ dv/masked_byte_pattern_scanner_unit_tb.sv @@
`timescale 1ns / 100ps
// stimulus and verdict for the masked byte pattern scanner: directed regions, then random
// regions under several pattern settings; depends on mbps_pkg, the scanner and mbps_scan_checker

module masked_byte_pattern_scanner_unit_tb;
   import mbps_pkg::*;

   localparam int RANDOM_WORDS = 750;
   localparam int SETTINGS_COUNT = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 4;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid;
   logic                       req_ready;
   logic [BYTE_BITS-1:0]       req_data_byte;
   logic                       req_region_first;
   logic                       req_region_last;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_found;
   logic [RSP_OFFSET_BITS-1:0] rsp_match_offset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [INDEX_BITS-1:0]      csr_index;
   logic [CSR_BITS-1:0]        csr_wdata;

   int fail_count;
   int words_outstanding;
   int results_checked;
   int cycle_count = 0;
   int words_sent = 0;
   int csr_writes = 0;
   int settings_loaded = 0;
   int burst_left = 0;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             ready_left = 0;

   // pattern as the stimulus side knows it, for planting matches
   logic [BYTE_BITS-1:0] pat_val [PATTERN_MAX];
   logic [BYTE_BITS-1:0] pat_mask [PATTERN_MAX];
   int                   pat_len = 1;

   masked_byte_pattern_scanner_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_region_first (req_region_first),
      .req_region_last  (req_region_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   mbps_scan_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_region_first  (req_region_first),
      .req_region_last   (req_region_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .words_outstanding (words_outstanding),
      .results_checked   (results_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // receiver back-pressure, switching at random between four modes
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_left <= $urandom_range(20, 150);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_COIN: begin
            rsp_ready <= ($urandom_range(0, 1) == 1);
         end
         READY_SPARSE: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= ((cycle_count % 7) < 3);
         end
      endcase
   end

   function automatic logic [CSR_BITS-1:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // entered and left at a falling edge; valid stays high through a burst
   task automatic send_word(input logic [BYTE_BITS-1:0] b, input logic is_first,
                            input logic is_last);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120) :
                                                    $urandom_range(1, 20);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data_byte = b;
      req_region_first = is_first;
      req_region_last = is_last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   // hold the sender until every expected result is back, then let the pipe empty
   task automatic drain();
      req_valid = 1'b0;
      while (words_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [CSR_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
   endtask

   task automatic load_pattern(input logic [CSR_BITS-1:0] vl, input logic [CSR_BITS-1:0] vh,
                               input logic [CSR_BITS-1:0] ml, input logic [CSR_BITS-1:0] mh,
                               input int len);
      logic [CSR_BITS-1:0] len_word;
      int                  i;
      drain();
      // junk above the length field should be ignored
      len_word = (rnd64() & ~CSR_BITS'(5'h1F)) | CSR_BITS'(len[LEN_BITS-1:0]);
      write_reg(REG_VALUES_LOW, vl);
      write_reg(REG_VALUES_HIGH, vh);
      write_reg(REG_MASKS_LOW, ml);
      write_reg(REG_MASKS_HIGH, mh);
      write_reg(REG_LENGTH, len_word);
      for (i = 0; i < PATTERN_MAX; i++) begin
         pat_val[i] = (i < 8) ? vl[8*i +: BYTE_BITS] : vh[8*(i-8) +: BYTE_BITS];
         pat_mask[i] = (i < 8) ? ml[8*i +: BYTE_BITS] : mh[8*(i-8) +: BYTE_BITS];
      end
      pat_len = (len[LEN_BITS-1:0] == 0) ? 1 :
                ((len[LEN_BITS-1:0] > LEN_CAP) ? LEN_CAP : int'(len[LEN_BITS-1:0]));
      settings_loaded++;
   endtask

   // one region of random bytes, maybe with a planted pattern or a near miss
   task automatic send_region(input int body_len, input logic planted, input logic near_miss,
                              input logic open_start, input logic open_end);
      logic [BYTE_BITS-1:0] body [$];
      int                   k;
      int                   at;
      int                   pick;
      int                   bit_i;
      logic                 is_first;
      logic                 is_last;
      for (k = 0; k < body_len; k++) begin
         body.push_back(BYTE_BITS'($urandom));
      end
      if (planted && body_len >= pat_len) begin
         at = $urandom_range(0, body_len - pat_len);
         for (k = 0; k < pat_len; k++) begin
            body[at+k] = (pat_val[k] & pat_mask[k]) | (BYTE_BITS'($urandom) & ~pat_mask[k]);
         end
         pick = $urandom_range(0, pat_len - 1);
         if (near_miss && pat_mask[pick] != '0) begin
            bit_i = $urandom_range(0, 7);
            while (!pat_mask[pick][bit_i]) bit_i = (bit_i + 1) % 8;
            body[at+pick][bit_i] = ~body[at+pick][bit_i];
         end
      end
      for (k = 0; k < body_len; k++) begin
         is_first = ((k == 0) && !open_start) || ($urandom_range(0, 59) == 0);
         is_last = ((k == body_len - 1) && !open_end) || ($urandom_range(0, 59) == 0);
         send_word(body[k], is_first, is_last);
      end
   endtask

   initial begin
      int                  setting;
      int                  target;
      int                  body_len;
      logic                paused;
      logic [CSR_BITS-1:0] ml;
      logic [CSR_BITS-1:0] mh;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_region_first = 1'b0;
      req_region_last = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_VALUES_LOW;
      csr_wdata = '0;
      paused = 1'b0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pat_val[i] = '0;
         pat_mask[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset pattern: length one, all wildcards, so the first byte matches
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b1);

      // 5A, F? nibble wildcard, 00
      load_pattern(64'h0000_0000_0000_F05A, '0, 64'h0000_0000_00FF_F0FF, '0, 3);
      // match at offset 1, then later bytes and the last byte stay silent
      send_word(8'h11, 1'b1, 1'b0);
      send_word(8'h5A, 1'b0, 1'b0);
      send_word(8'hF7, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h5A, 1'b0, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hFF, 1'b0, 1'b1);
      // no match in region
      send_word(8'h5A, 1'b1, 1'b0);
      send_word(8'hF0, 1'b0, 1'b0);
      send_word(8'h01, 1'b0, 1'b1);
      // implicit region start, match on the last byte
      send_word(8'h5A, 1'b0, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      // region shorter than the pattern
      send_word(8'h5A, 1'b1, 1'b1);
      // new region start in the middle clears the partial match
      send_word(8'h5A, 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h5A, 1'b1, 1'b0);
      send_word(8'hF3, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);

      for (setting = 0; setting < SETTINGS_COUNT; setting++) begin
         ml = rnd64();
         mh = rnd64();
         case (setting)
            0: load_pattern(rnd64(), rnd64(), '1, '1, 16);
            1: load_pattern('0, '0, '0, '0, 0);
            2: load_pattern(rnd64() & ml, rnd64() & mh, ml, mh, 31);
            3: load_pattern(rnd64() & 64'hF0F0_F0F0_F0F0_F0F0, rnd64() & 64'h0F0F_0F0F_0F0F_0F0F,
                            64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F, 17);
            4: load_pattern(rnd64() & ml, rnd64() & mh, ml, mh, $urandom_range(1, 16));
            5: load_pattern(rnd64(), rnd64(), '1, '1, 2);
            6: load_pattern(rnd64(), rnd64(), ml, mh, $urandom_range(1, 4));
            default: load_pattern(rnd64() & ml, rnd64() & mh, ml, mh, 1);
         endcase
         target = words_sent + RANDOM_WORDS / SETTINGS_COUNT;
         while (words_sent < target) begin
            body_len = ($urandom_range(0, 99) < 8) ? $urandom_range(40, 160) :
                                                     $urandom_range(1, 2 * pat_len + 8);
            send_region(body_len, $urandom_range(0, 99) < 70, $urandom_range(0, 3) == 0,
                        $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
            if (setting == 4 && !paused && words_sent >= target - 40) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      drain();
      $display("%0d bytes scanned over %0d pattern settings, %0d results checked",
               words_sent, settings_loaded + 1, results_checked);
      $display("%0d register writes, lengths from 0 to 31 and masks from none to all",
               csr_writes);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, words_outstanding);
      $display("== FAIL ==");
      $finish;
   end

endmodule
